// ===== src/rlti_pkg.sv =====
// shared types and constants for the radix literal to int128 converter
`timescale 1ns / 1ps

package rlti_pkg;

    // widths of the data paths
    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned VALUE_W = 128;
    localparam int unsigned HALF_W  = 64;
    localparam int unsigned DIGIT_W = 4;
    localparam int unsigned POS_W   = 2;
    // accumulator with head room for a multiply by 16 plus a digit
    localparam int unsigned EXT_W   = VALUE_W + 5;

    // character positions
    localparam logic [POS_W-1:0] POS_FIRST  = 2'd0;
    localparam logic [POS_W-1:0] POS_SECOND = 2'd1;
    localparam logic [POS_W-1:0] POS_LATER  = 2'd2;

    // characters with a meaning of their own
    localparam logic [CHAR_W-1:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [CHAR_W-1:0] CH_MINUS      = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_PLUS       = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_ZERO       = 8'h30;
    localparam logic [CHAR_W-1:0] CH_ONE        = 8'h31;
    localparam logic [CHAR_W-1:0] CH_NINE       = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UPPER_A    = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UPPER_F    = 8'h46;
    localparam logic [CHAR_W-1:0] CH_LOWER_A    = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LOWER_F    = 8'h66;
    localparam logic [CHAR_W-1:0] HEX_LETTER_BASE = 8'd10;

    // radix codes; the fourth code takes a sign but no digits
    typedef enum logic [1:0] {
        RADIX_BIN  = 2'd0,
        RADIX_DEC  = 2'd1,
        RADIX_HEX  = 2'd2,
        RADIX_NONE = 2'd3
    } t_radix;

    // classification of one character
    typedef struct packed {
        logic               ignored;   // prefix, plus sign or underscore
        logic               set_neg;   // minus sign in the sign position
        logic               is_digit;  // valid digit of the held radix
        logic [DIGIT_W-1:0] digit;
    } t_char_info;

endpackage

// ===== src/rlti_decode.sv =====
// character classifier: prefix, sign, separator and digit value
`timescale 1ns / 1ps

module rlti_decode (
    input  rlti_pkg::t_radix                 i_radix,
    input  logic [rlti_pkg::POS_W-1:0]       i_pos,
    input  logic [rlti_pkg::CHAR_W-1:0]      i_char,
    output rlti_pkg::t_char_info             o_info
);
    import rlti_pkg::*;

    // prefix, sign and separator flags and digit value for the given radix
    always_comb begin
        logic prefixed;
        logic sign_here;
        logic [CHAR_W-1:0] ofs;
        prefixed  = (i_radix == RADIX_BIN) || (i_radix == RADIX_HEX);
        sign_here = prefixed ? (i_pos == POS_SECOND) : (i_pos == POS_FIRST);
        ofs       = '0;
        o_info    = '0;
        priority if (prefixed && (i_pos == POS_FIRST)) begin
            o_info.ignored = 1'b1;
        end else if (sign_here && (i_char == CH_MINUS)) begin
            o_info.set_neg = 1'b1;
        end else if (sign_here && (i_char == CH_PLUS)) begin
            o_info.ignored = 1'b1;
        end else if (i_char == CH_UNDERSCORE) begin
            o_info.ignored = 1'b1;
        end else if ((i_radix == RADIX_BIN) && (i_char >= CH_ZERO) && (i_char <= CH_ONE)) begin
            ofs             = i_char - CH_ZERO;
            o_info.is_digit = 1'b1;
        end else if (((i_radix == RADIX_DEC) || (i_radix == RADIX_HEX))
                     && (i_char >= CH_ZERO) && (i_char <= CH_NINE)) begin
            ofs             = i_char - CH_ZERO;
            o_info.is_digit = 1'b1;
        end else if ((i_radix == RADIX_HEX) && (i_char >= CH_UPPER_A)
                     && (i_char <= CH_UPPER_F)) begin
            ofs             = i_char - CH_UPPER_A + HEX_LETTER_BASE;
            o_info.is_digit = 1'b1;
        end else if ((i_radix == RADIX_HEX) && (i_char >= CH_LOWER_A)
                     && (i_char <= CH_LOWER_F)) begin
            ofs             = i_char - CH_LOWER_A + HEX_LETTER_BASE;
            o_info.is_digit = 1'b1;
        end else begin
            // invalid character: all flags stay low
            ofs = '0;
        end
        o_info.digit = ofs[DIGIT_W-1:0];
    end

endmodule

// ===== src/rlti_mac.sv =====
// multiply by the radix and add or subtract one digit, with range check
`timescale 1ns / 1ps

module rlti_mac (
    input  logic [rlti_pkg::VALUE_W-1:0] i_sum,
    input  logic                         i_neg,
    input  rlti_pkg::t_radix             i_radix,
    input  logic [rlti_pkg::DIGIT_W-1:0] i_digit,
    output logic [rlti_pkg::VALUE_W-1:0] o_sum,
    output logic                         o_overflow
);
    import rlti_pkg::*;

    logic [EXT_W-1:0] ext;
    logic [EXT_W-1:0] prod;
    logic [EXT_W-1:0] dig;
    logic [EXT_W-1:0] res;

    // sign extend so that the exact result always fits
    assign ext = {{(EXT_W-VALUE_W){i_sum[VALUE_W-1]}}, i_sum};
    assign dig = {{(EXT_W-DIGIT_W){1'b0}}, i_digit};

    // radix multiply as shifts and adds
    always_comb begin
        unique case (i_radix)
            RADIX_BIN: prod = ext << 1;
            RADIX_DEC: prod = (ext << 3) + (ext << 1);
            RADIX_HEX: prod = ext << 4;
            default:   prod = ext;
        endcase
    end

    // negative literals grow downwards
    assign res = i_neg ? (prod - dig) : (prod + dig);

    // in range when every bit above the sign bit copies it
    assign o_overflow = !((&res[EXT_W-1:VALUE_W-1]) || !(|res[EXT_W-1:VALUE_W-1]));
    assign o_sum      = res[VALUE_W-1:0];

endmodule

// ===== src/radix_literal_to_int128.sv =====
// top level: input stage, literal state and result register
`timescale 1ns / 1ps

// Converts a number literal, one character per request, into a signed
// 128-bit integer.
// Input channel: i_s_tdata carries the character, i_s_tuser the radix code
// (0 binary, 1 decimal, 2 hexadecimal, sampled on a literal's first
// character) and i_s_tlast marks the final character of the literal.
// Output channel: one request per literal; o_m_tuser is the ok flag and
// o_m_tdata holds the upper 64 bits in [63:0] and the lower in [127:64],
// both zero when the literal is rejected.
// Throughput: one character per cycle, except while a last character waits
// for a stalled receiver. The running value, multiplied by the radix and
// extended by one digit, is updated directly from the input register, so
// the next character follows at once. A result passes through the input
// register, then the result register.
// When the receiver stalls, the result waits in the result register and
// characters keep flowing until a further last character reaches the
// input register; it then holds there and o_s_tready drops.
// Reset clears the literal state and empties both registers.

module radix_literal_to_int128 (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    input  logic [rlti_pkg::CHAR_W-1:0]          i_s_tdata,  // character
    input  logic [1:0]                           i_s_tuser,  // radix_select
    input  logic                                 i_s_tlast,  // last
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    output logic [rlti_pkg::VALUE_W-1:0]         o_m_tdata,  // value_high, value_low
    output logic                                 o_m_tuser   // accepted
);
    import rlti_pkg::*;

    // input register
    logic                 r_in_valid;
    logic [CHAR_W-1:0]    r_in_char;
    t_radix               r_in_radix;
    logic                 r_in_last;

    // literal state
    logic [VALUE_W-1:0]   r_sum,    n_sum;
    logic                 r_neg,    n_neg;
    logic                 r_failed, n_failed;
    logic [POS_W-1:0]     r_pos,    n_pos;
    t_radix               r_radix,  n_radix;

    // result register
    logic                 r_out_valid;
    logic [VALUE_W-1:0]   r_out_data;
    logic                 r_out_ok;

    logic                 advance;
    logic                 done;
    t_radix               cur_radix;
    t_char_info           info;
    logic [VALUE_W-1:0]   mac_sum;
    logic                 mac_ovf;
    logic                 step_fail;
    logic                 take_digit;

    // value_high in the low half, value_low in the high half
    function automatic logic [VALUE_W-1:0] n_sum_hold(
        input logic               sel,
        input logic [VALUE_W-1:0] a,
        input logic [VALUE_W-1:0] b
    );
        logic [VALUE_W-1:0] v;
        v = sel ? a : b;
        return {v[HALF_W-1:0], v[VALUE_W-1:HALF_W]};
    endfunction

    // handshake
    assign done       = r_in_valid && r_in_last;
    assign advance    = r_in_valid && (!r_in_last || !r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || advance;

    // radix is sampled on the first character
    assign cur_radix = (r_pos == POS_FIRST) ? r_in_radix : r_radix;

    rlti_decode u_decode (
        .i_radix (cur_radix),
        .i_pos   (r_pos),
        .i_char  (r_in_char),
        .o_info  (info)
    );

    rlti_mac u_mac (
        .i_sum      (r_sum),
        .i_neg      (r_neg),
        .i_radix    (cur_radix),
        .i_digit    (info.digit),
        .o_sum      (mac_sum),
        .o_overflow (mac_ovf)
    );

    // outcome of the current character
    assign take_digit = !r_failed && info.is_digit && !mac_ovf;
    assign step_fail  = r_failed
                     || (!info.ignored && !info.set_neg && (!info.is_digit || mac_ovf));

    // next literal state
    always_comb begin
        n_sum    = take_digit ? mac_sum : r_sum;
        n_neg    = r_neg || (!r_failed && info.set_neg);
        n_failed = step_fail;
        n_radix  = cur_radix;
        n_pos    = (r_pos == POS_LATER) ? POS_LATER : r_pos + POS_SECOND;
        if (r_in_last) begin
            n_sum    = '0;
            n_neg    = 1'b0;
            n_failed = 1'b0;
            n_radix  = RADIX_BIN;
            n_pos    = POS_FIRST;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_char  <= i_s_tdata;
            r_in_radix <= t_radix'(i_s_tuser);
            r_in_last  <= i_s_tlast;
        end
    end

    // literal state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum    <= '0;
            r_neg    <= 1'b0;
            r_failed <= 1'b0;
            r_pos    <= POS_FIRST;
            r_radix  <= RADIX_BIN;
        end else if (advance) begin
            r_sum    <= n_sum;
            r_neg    <= n_neg;
            r_failed <= n_failed;
            r_pos    <= n_pos;
            r_radix  <= n_radix;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && done) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && done) begin
            r_out_ok   <= !step_fail;
            r_out_data <= step_fail ? '0
                        : {n_sum_hold(take_digit, mac_sum, r_sum)};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_ok;

`ifndef NO_ASSERTIONS
    // a finished literal always lands in the result register
    a_result_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && done |=> r_out_valid)
        else $error("result missing after last character");

    // state is back to reset after a literal
    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && done |=> (r_sum == '0) && !r_neg && !r_failed && (r_pos == POS_FIRST))
        else $error("literal state not cleared");

    // a rejected literal reports a zero value
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_ok |-> (r_out_data == '0))
        else $error("rejected literal with non-zero value");

    // after an error the running value is frozen
    a_failed_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_failed && !(advance && done) |=> $stable(r_sum))
        else $error("value changed after error");

    // sign of the running value matches the sign flag
    a_sign_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_neg && !r_sum[VALUE_W-1]) || (r_neg && (r_sum[VALUE_W-1] || (r_sum == '0))))
        else $error("running value sign mismatch");
`endif

endmodule

// ===== bench/literal_monitor.sv =====
// channel monitor: predicts each parsed literal value and compares results
`timescale 1ns / 1ps

module literal_monitor (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_tvalid,
    input  logic                         i_s_tready,
    input  logic [rlti_pkg::CHAR_W-1:0]  i_s_tdata,  // character
    input  logic [1:0]                   i_s_tuser,  // radix_select
    input  logic                         i_s_tlast,  // last
    input  logic                         i_m_tvalid,
    input  logic                         i_m_tready,
    input  logic [rlti_pkg::VALUE_W-1:0] i_m_tdata,  // value_high, value_low
    input  logic                         i_m_tuser,  // accepted
    output int                           o_error_count,
    output int                           o_pending,
    output int                           o_result_count,
    output int                           o_accepted_count
);

    import rlti_pkg::*;

    typedef struct {
        logic              ok;
        logic [HALF_W-1:0] hi;
        logic [HALF_W-1:0] lo;
    } t_literal_value;

    // parsed values still waiting for their result request
    t_literal_value value_queue[$];

    // running state of the literal being parsed
    logic [VALUE_W-1:0] run_value;
    logic               run_neg;
    logic               run_fail;
    logic [POS_W-1:0]   run_pos;
    t_radix             run_radix;

    int mismatch_count;
    int result_count;
    int accepted_count;

    assign o_error_count    = mismatch_count;
    assign o_result_count   = result_count;
    assign o_accepted_count = accepted_count;

    task automatic report_mismatch(input string field, input logic [VALUE_W-1:0] got,
                                   input logic [VALUE_W-1:0] want);
        $display("result %0d: %s is %h, expected %h", result_count, field, got, want);
        mismatch_count++;
    endtask

    task automatic clear_literal();
        run_value = '0;
        run_neg   = 1'b0;
        run_fail  = 1'b0;
        run_pos   = POS_FIRST;
        run_radix = RADIX_BIN;
    endtask

    // digit weight of a character in the held radix, -1 when it is no digit
    function automatic int digit_value(input t_radix rdx, input logic [CHAR_W-1:0] ch);
        int dig;
        dig = -1;
        case (rdx)
            RADIX_BIN: begin
                if (ch == CH_ZERO || ch == CH_ONE) dig = int'(ch) - int'(CH_ZERO);
            end
            RADIX_DEC: begin
                if (ch >= CH_ZERO && ch <= CH_NINE) dig = int'(ch) - int'(CH_ZERO);
            end
            RADIX_HEX: begin
                if (ch >= CH_ZERO && ch <= CH_NINE)
                    dig = int'(ch) - int'(CH_ZERO);
                else if (ch >= CH_UPPER_A && ch <= CH_UPPER_F)
                    dig = int'(ch) - int'(CH_UPPER_A) + int'(HEX_LETTER_BASE);
                else if (ch >= CH_LOWER_A && ch <= CH_LOWER_F)
                    dig = int'(ch) - int'(CH_LOWER_A) + int'(HEX_LETTER_BASE);
            end
            default: dig = -1;
        endcase
        return dig;
    endfunction

    // one character into the running value; a last character yields a result
    task automatic parse_char(input logic [1:0] sel, input logic [CHAR_W-1:0] ch,
                              input logic lst);
        logic               prefixed;
        logic [POS_W-1:0]   sign_pos;
        int                 dig;
        int                 base;
        logic [VALUE_W-1:0] mag;
        logic [VALUE_W+7:0] ext;
        logic               over;
        t_literal_value     res;
        if (run_pos == POS_FIRST) run_radix = t_radix'(sel);
        prefixed = (run_radix == RADIX_BIN || run_radix == RADIX_HEX);
        sign_pos = prefixed ? POS_SECOND : POS_FIRST;
        if (!run_fail) begin
            if (prefixed && run_pos == POS_FIRST) begin
                // prefix skipped unchecked
            end else if (run_pos == sign_pos && ch == CH_MINUS) begin
                run_neg = 1'b1;
            end else if (run_pos == sign_pos && ch == CH_PLUS) begin
                // explicit plus sign
            end else if (ch == CH_UNDERSCORE) begin
                // separator
            end else begin
                dig = digit_value(run_radix, ch);
                if (dig < 0) begin
                    run_fail = 1'b1;
                end else begin
                    case (run_radix)
                        RADIX_BIN: base = 2;
                        RADIX_DEC: base = 10;
                        default:   base = 16;
                    endcase
                    // work on the magnitude, then check it against the signed range
                    mag  = run_neg ? (~run_value + 1'b1) : run_value;
                    ext  = {8'd0, mag} * (VALUE_W+8)'(base) + (VALUE_W+8)'(dig);
                    over = |ext[VALUE_W+7:VALUE_W];
                    if (run_neg) over = over | (ext[VALUE_W-1:0] > {1'b1, 127'd0});
                    else         over = over | ext[VALUE_W-1];
                    if (over) run_fail = 1'b1;
                    else run_value = run_neg ? (~ext[VALUE_W-1:0] + 1'b1) : ext[VALUE_W-1:0];
                end
            end
        end
        if (run_pos != POS_LATER) run_pos = run_pos + 1'b1;
        if (lst) begin
            res.ok = !run_fail;
            res.hi = run_fail ? '0 : run_value[VALUE_W-1:HALF_W];
            res.lo = run_fail ? '0 : run_value[HALF_W-1:0];
            value_queue.push_back(res);
            clear_literal();
        end
    endtask

    always @(posedge i_clk) begin
        t_literal_value want;
        if (!i_rst_n) begin
            clear_literal();
            value_queue.delete();
            mismatch_count = 0;
            result_count   = 0;
            accepted_count = 0;
        end else begin
            // result side first, an expectation never matches in its own cycle
            if (i_m_tvalid && i_m_tready) begin
                result_count++;
                if (value_queue.size() == 0) begin
                    report_mismatch("unexpected result", i_m_tdata, '0);
                end else begin
                    want = value_queue.pop_front();
                    if (want.ok) accepted_count++;
                    if (i_m_tuser !== want.ok)
                        report_mismatch("ok flag", VALUE_W'(i_m_tuser), VALUE_W'(want.ok));
                    if (i_m_tdata[HALF_W-1:0] !== want.hi)
                        report_mismatch("value_high", VALUE_W'(i_m_tdata[HALF_W-1:0]),
                                        VALUE_W'(want.hi));
                    if (i_m_tdata[VALUE_W-1:HALF_W] !== want.lo)
                        report_mismatch("value_low", VALUE_W'(i_m_tdata[VALUE_W-1:HALF_W]),
                                        VALUE_W'(want.lo));
                end
            end
            // character request
            if (i_s_tvalid && i_s_tready) parse_char(i_s_tuser, i_s_tdata, i_s_tlast);
        end
        o_pending <= value_queue.size();
    end

endmodule

// ===== bench/testbench.sv =====
// top of the bench: clock, reset, literal stimulus, receiver stalls and verdict
`timescale 1ns / 1ps

module testbench;

    import rlti_pkg::*;

    localparam int RANDOM_CHARS = 575;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_LIMIT  = 20000;

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [CHAR_W-1:0]   s_tdata;
    logic [1:0]          s_tuser;
    logic                s_tlast;
    logic                m_tvalid;
    logic                m_tready;
    logic [VALUE_W-1:0]  m_tdata;
    logic                m_tuser;

    int error_count;
    int pending;
    int result_count;
    int accepted_count;

    // stimulus controls
    logic [CHAR_W-1:0] lit_buf[$];
    int                chars_sent;
    int                literal_count;
    int                tx_gap_pct;
    int                rx_gap_pct;
    logic              hold_rx_req;

    radix_literal_to_int128 u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .i_s_tlast  (s_tlast),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

    literal_monitor u_monitor (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_s_tvalid       (s_tvalid),
        .i_s_tready       (s_tready),
        .i_s_tdata        (s_tdata),
        .i_s_tuser        (s_tuser),
        .i_s_tlast        (s_tlast),
        .i_m_tvalid       (m_tvalid),
        .i_m_tready       (m_tready),
        .i_m_tdata        (m_tdata),
        .i_m_tuser        (m_tuser),
        .o_error_count    (error_count),
        .o_pending        (pending),
        .o_result_count   (result_count),
        .o_accepted_count (accepted_count)
    );

    // clock
    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // run limit
    initial begin
        #4_800_000;
        $display("run limit reached with %0d results outstanding", pending);
        $display("CHECK FAILED");
        $finish;
    end

    // receiver: random stall bursts and one long hold-off on request
    initial begin
        logic hold_done;
        hold_done = 1'b0;
        m_tready  = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_rx_req && !hold_done) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_done = 1'b1;
            end else if ($urandom_range(0, 99) < rx_gap_pct) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 18) - 1) @(negedge clk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // one character request, entered and left at a falling edge
    task automatic put_char(input logic [1:0] rdx, input logic [CHAR_W-1:0] ch,
                            input logic lst);
        if ($urandom_range(0, 99) < tx_gap_pct) begin
            s_tvalid <= 1'b0;
            s_tdata  <= CHAR_W'($urandom);
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tuser  <= rdx;
        s_tlast  <= lst;
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
        chars_sent++;
    endtask

    // radix code only counts on the first character, later ones get noise
    task automatic send_literal(input logic [1:0] rdx);
        for (int i = 0; i < lit_buf.size(); i++)
            put_char((i == 0) ? rdx : 2'($urandom), lit_buf[i], i == lit_buf.size() - 1);
        literal_count++;
    endtask

    task automatic send_text(input logic [1:0] rdx, input string txt);
        lit_buf.delete();
        for (int i = 0; i < txt.len(); i++) lit_buf.push_back(txt[i]);
        send_literal(rdx);
    endtask

    function automatic logic [CHAR_W-1:0] random_digit(input logic [1:0] rdx);
        string hex_set;
        hex_set = "0123456789abcdefABCDEF";
        case (rdx)
            RADIX_BIN: return CH_ZERO + CHAR_W'($urandom_range(0, 1));
            RADIX_DEC: return CH_ZERO + CHAR_W'($urandom_range(0, 9));
            default:   return hex_set[$urandom_range(0, 21)];
        endcase
    endfunction

    // mostly well-formed literals, some near the range limits, some broken
    task automatic build_literal(output logic [1:0] rdx);
        int                kind;
        int                len;
        int                pos;
        logic              long_lit;
        logic [CHAR_W-1:0] ch;
        lit_buf.delete();
        kind = $urandom_range(0, 99);
        rdx  = (kind < 6) ? RADIX_NONE : 2'($urandom_range(0, 2));
        if (rdx == RADIX_BIN || rdx == RADIX_HEX) begin
            case ($urandom_range(0, 2))
                0:       ch = (rdx == RADIX_BIN) ? "b" : "x";
                1:       ch = "0";
                default: ch = CHAR_W'($urandom);
            endcase
            lit_buf.push_back(ch);
        end
        case ($urandom_range(0, 3))
            1:       lit_buf.push_back(CH_MINUS);
            2:       lit_buf.push_back(CH_PLUS);
            default: ;
        endcase
        long_lit = ($urandom_range(0, 7) == 0);
        if (long_lit) begin
            case (rdx)
                RADIX_BIN: len = ($urandom_range(0, 3) == 0) ? $urandom_range(124, 129)
                                                             : $urandom_range(20, 40);
                RADIX_DEC: len = $urandom_range(36, 40);
                default:   len = $urandom_range(29, 33);
            endcase
        end else begin
            len = $urandom_range(0, 10);
        end
        for (int k = 0; k < len; k++) begin
            if ($urandom_range(0, 9) == 0) lit_buf.push_back(CH_UNDERSCORE);
            ch = random_digit(rdx);
            // lead digit close to the top of the range
            if (long_lit && k == 0 && rdx == RADIX_HEX) ch = $urandom_range(0, 1) ? "7" : "8";
            if (long_lit && k == 0 && rdx == RADIX_DEC) ch = "1";
            lit_buf.push_back(ch);
        end
        // broken literals: a stray byte or a misplaced sign
        if (kind >= 80) begin
            case ($urandom_range(0, 3))
                0:       ch = CH_MINUS;
                1:       ch = CH_PLUS;
                default: ch = CHAR_W'($urandom);
            endcase
            pos = $urandom_range(0, lit_buf.size());
            lit_buf.insert(pos, ch);
        end
        if (lit_buf.size() == 0) lit_buf.push_back(random_digit(rdx));
    endtask

    // main stimulus
    initial begin
        logic [1:0] rdx;
        int         lit_idx;
        int         start_chars;
        int         waited;
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        s_tlast     = 1'b0;
        hold_rx_req = 1'b0;
        tx_gap_pct  = 0;
        rx_gap_pct  = 0;
        chars_sent  = 0;
        literal_count = 0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: range limits, signs, separators, errors, spare radix code
        tx_gap_pct = 10;
        rx_gap_pct = 10;
        send_text(RADIX_DEC, "0");
        send_text(RADIX_DEC, "-0");
        send_text(RADIX_DEC, "+7");
        send_text(RADIX_DEC, "170141183460469231731687303715884105727");
        send_text(RADIX_DEC, "-170141183460469231731687303715884105728");
        send_text(RADIX_DEC, "170141183460469231731687303715884105728");
        send_text(RADIX_DEC, "-170141183460469231731687303715884105729");
        send_text(RADIX_HEX, "x7fffffffffffffffffffffffffffffff");
        send_text(RADIX_HEX, "x-80000000000000000000000000000000");
        send_text(RADIX_HEX, "x-80000000000000000000000000000001");
        send_text(RADIX_HEX, "x80000000000000000000000000000000");
        send_text(RADIX_HEX, "x100000000000000000000000000000000");
        send_text(RADIX_HEX, "xDeAd_bEeF_09");
        send_text(RADIX_BIN, "b-1011");
        send_text(RADIX_BIN, "b2");
        send_text(RADIX_BIN, "b");
        send_text(RADIX_BIN, "b+-1");
        send_text(RADIX_DEC, "-");
        send_text(RADIX_DEC, "___");
        send_text(RADIX_DEC, "1-2");
        send_text(RADIX_DEC, "z123");
        send_text(RADIX_NONE, "-__");
        send_text(RADIX_NONE, "+5");
        lit_buf.delete();
        lit_buf.push_back(8'hFF);
        lit_buf.push_back("F");
        lit_buf.push_back("f");
        send_literal(RADIX_HEX);

        // random literals
        lit_idx     = 0;
        start_chars = chars_sent;
        while (chars_sent - start_chars < RANDOM_CHARS) begin
            if (lit_idx % 16 == 0) begin
                case ($urandom_range(0, 2))
                    0:       tx_gap_pct = 0;
                    1:       tx_gap_pct = 10;
                    default: tx_gap_pct = 30;
                endcase
                case ($urandom_range(0, 2))
                    0:       rx_gap_pct = 0;
                    1:       rx_gap_pct = 10;
                    default: rx_gap_pct = 30;
                endcase
            end
            // long receiver hold-off while characters keep coming
            if (lit_idx == 15) hold_rx_req = 1'b1;
            // sender pause until every result has come back
            if (lit_idx == 30) begin
                s_tvalid <= 1'b0;
                do @(negedge clk); while (pending != 0);
            end
            // quiet tail with no idling
            if (chars_sent - start_chars > RANDOM_CHARS - 150) begin
                tx_gap_pct = 0;
                rx_gap_pct = 0;
            end
            build_literal(rdx);
            send_literal(rdx);
            lit_idx++;
        end
        s_tvalid <= 1'b0;

        // drain
        waited = 0;
        while (pending != 0 && waited < DRAIN_LIMIT) begin
            @(negedge clk);
            waited++;
        end
        repeat (8) @(negedge clk);

        $display("covered %0d literals, %0d characters, radix 2, 10, 16 and the spare code",
                 literal_count, chars_sent);
        $display("%0d results checked: %0d accepted, %0d rejected, under sender and receiver stalls",
                 result_count, accepted_count, result_count - accepted_count);
        if (pending != 0) $display("%0d expected results never arrived", pending);
        if (error_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
